[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of the core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/i420ta_pkg.sv]
// Package for the I420 transpose address generator: widths, register
// indexes, plane codes, reset constants and the dimension clamp function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i420ta_pkg;

    localparam int MAX_DIM = 4096;

    localparam int DIM_W  = 13;
    localparam int ADDR_W = 25;
    localparam int PIX_W  = 8;
    localparam int DATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int DIM5_W = DIM_W + 3;

    // Largest even dimension the register can express.
    localparam int REG_TOP = (1 << DIM_W) - 2;
    localparam int TOP_RAW = MAX_DIM & ~1;
    localparam int EFF_TOP = (TOP_RAW < 2) ? 2 : ((TOP_RAW > REG_TOP) ? REG_TOP : TOP_RAW);
    localparam int CNT_W   = (EFF_TOP > 2) ? $clog2(EFF_TOP) : 1;
    localparam int CMP_W   = ((CNT_W + 1) > DIM_W) ? (CNT_W + 1) : DIM_W;

    // Register indexes (paddr bit 2)
    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    // Plane codes
    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;
    localparam logic [1:0] PLANE_V = 2'd2;

    localparam int RST_W = 640;
    localparam int RST_H = 480;
    localparam int RST_W_EFF = (RST_W < 2) ? 2 : ((RST_W > EFF_TOP) ? EFF_TOP : RST_W);
    localparam int RST_H_EFF = (RST_H < 2) ? 2 : ((RST_H > EFF_TOP) ? EFF_TOP : RST_H);
    localparam int RST_LUMA   = RST_W_EFF * RST_H_EFF;
    localparam int RST_LUMA54 = RST_LUMA + RST_LUMA / 4;

    typedef struct packed {
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [ADDR_W-1:0] luma;
        logic [ADDR_W-1:0] luma54;
    } t_dims;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_addr;
        logic [PIX_W-1:0]  pixel;
        logic              frame_last;
    } t_result;

    // Drop bit 0, then clamp to 2 .. EFF_TOP.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        e = {v[DIM_W-1:1], 1'b0};
        if (e < DIM_W'(2)) begin
            e = DIM_W'(2);
        end else if (e > DIM_W'(EFF_TOP)) begin
            e = DIM_W'(EFF_TOP);
        end
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/core/i420_frame_transpose_addr.sv]
// Top level of the I420 transpose address generator: APB registers,
// address counters and output buffer. Uses i420ta_pkg and the i420ta_* modules.
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_pixel[7:0]
// output    out        o_out_valid / i_out_ready  o_dest_addr[24:0], o_pixel_out, o_frame_last
// config    in         psel/penable/pwrite/pready paddr[2:0], pwdata, prdata (read)
//
// One byte per cycle sustained while results are taken; a result is registered
// from the address counters into the output register (skid register on a stall).
// The two-entry output buffer lets one more transaction in while a result
// stalls; o_in_ready drops only when both entries are full.
// Synchronous active-low reset clears counters, buffer state and registers
// to 640 x 480; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module i420_frame_transpose_addr
    import i420ta_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [PIX_W-1:0]   i_pixel,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [ADDR_W-1:0]  o_dest_addr,
    output logic      [PIX_W-1:0]   o_pixel_out,
    output logic                    o_frame_last
);

    t_dims   dims;
    t_result gen_result, out_result;
    logic    step;

    assign step = i_in_valid && o_in_ready;

    i420ta_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    i420ta_addr_gen u_addr_gen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dims   (dims),
        .i_step   (step),
        .i_pixel  (i_pixel),
        .o_result (gen_result)
    );

    i420ta_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (gen_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_result)
    );

    assign o_dest_addr  = out_result.dest_addr;
    assign o_pixel_out  = out_result.pixel;
    assign o_frame_last = out_result.frame_last;

endmodule

`default_nettype wire

[rtl/core/i420ta_cfg.sv]
// APB register file for frame width and height, with the clamped sizes
// and the chroma plane bases worked out at write time. Uses i420ta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i420ta_cfg
    import i420ta_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output t_dims                   o_dims
);

    logic [DIM_W-1:0]  r_src_width, r_src_height;
    logic [DIM_W-1:0]  r_w, r_h;
    logic [DIM5_W-1:0] r_w5, r_h5;
    logic [ADDR_W-1:0] r_luma, r_luma54;

    logic                      wr_en;
    logic [DIM_W-1:0]          new_dim;
    logic [DIM5_W-1:0]         new_dim5;
    logic [2*DIM_W-1:0]        prod_luma;
    logic [DIM_W+DIM5_W-1:0]   prod_luma5;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    assign new_dim  = eff_dim(pwdata[DIM_W-1:0]);
    assign new_dim5 = {1'b0, new_dim, 2'b00} + {3'b000, new_dim};

    // One product against the other stored dimension; 5/4 base from 5*dim.
    always_comb begin
        if (paddr[2] == REG_SRC_WIDTH) begin
            prod_luma  = new_dim * r_h;
            prod_luma5 = new_dim * r_h5;
        end else begin
            prod_luma  = r_w * new_dim;
            prod_luma5 = r_w5 * new_dim;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_W'(RST_W);
            r_src_height <= DIM_W'(RST_H);
            r_w          <= DIM_W'(RST_W_EFF);
            r_h          <= DIM_W'(RST_H_EFF);
            r_w5         <= DIM5_W'(5 * RST_W_EFF);
            r_h5         <= DIM5_W'(5 * RST_H_EFF);
            r_luma       <= ADDR_W'(RST_LUMA);
            r_luma54     <= ADDR_W'(RST_LUMA54);
        end else if (wr_en) begin
            r_luma   <= prod_luma[ADDR_W-1:0];
            r_luma54 <= prod_luma5[ADDR_W+1:2];
            if (paddr[2] == REG_SRC_WIDTH) begin
                r_src_width <= pwdata[DIM_W-1:0];
                r_w         <= new_dim;
                r_w5        <= new_dim5;
            end else begin
                r_src_height <= pwdata[DIM_W-1:0];
                r_h          <= new_dim;
                r_h5         <= new_dim5;
            end
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SRC_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, r_src_width};
            REG_SRC_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, r_src_height};
            default:        prdata = '0;
        endcase
    end

    assign o_dims.w      = r_w;
    assign o_dims.h      = r_h;
    assign o_dims.luma   = r_luma;
    assign o_dims.luma54 = r_luma54;

endmodule

`default_nettype wire

[rtl/core/i420ta_addr_gen.sv]
// Plane, row and column counters with the destination address accumulator.
// Gives the result of the current byte and steps on each accepted byte.
// Uses i420ta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i420ta_addr_gen
    import i420ta_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dims            i_dims,
    input  wire logic             i_step,
    input  wire logic [PIX_W-1:0] i_pixel,
    output t_result               o_result
);

    logic [1:0]        r_plane;
    logic [CNT_W-1:0]  r_row, r_col;
    logic [ADDR_W-1:0] r_row_start, r_accum;

    logic [DIM_W-1:0]  pw, ph;
    logic              last_col, last_row, last_v;
    logic [ADDR_W-1:0] next_base;

    assign pw = (r_plane == PLANE_Y) ? i_dims.w : {1'b0, i_dims.w[DIM_W-1:1]};
    assign ph = (r_plane == PLANE_Y) ? i_dims.h : {1'b0, i_dims.h[DIM_W-1:1]};

    // A counter past a shrunken limit still counts as last.
    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= CMP_W'(pw);
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(ph);
    assign last_v   = (r_plane >= PLANE_V) && last_col && last_row;

    always_comb begin
        case (r_plane)
            PLANE_Y: next_base = i_dims.luma;
            PLANE_U: next_base = i_dims.luma54;
            default: next_base = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane     <= PLANE_Y;
            r_row       <= '0;
            r_col       <= '0;
            r_row_start <= '0;
            r_accum     <= '0;
        end else if (i_step) begin
            if (!last_col) begin
                r_col   <= r_col + CNT_W'(1);
                r_accum <= r_accum + ADDR_W'(ph);
            end else if (!last_row) begin
                r_col       <= '0;
                r_row       <= r_row + CNT_W'(1);
                r_row_start <= r_row_start + ADDR_W'(1);
                r_accum     <= r_row_start + ADDR_W'(1);
            end else begin
                // advance to next plane, wrap after V
                r_col       <= '0;
                r_row       <= '0;
                r_plane     <= (r_plane == PLANE_Y) ? PLANE_U :
                               (r_plane == PLANE_U) ? PLANE_V : PLANE_Y;
                r_row_start <= next_base;
                r_accum     <= next_base;
            end
        end
    end

    assign o_result.dest_addr  = r_accum;
    assign o_result.pixel      = i_pixel;
    assign o_result.frame_last = last_v;

endmodule

`default_nettype wire

[rtl/core/i420ta_skid.sv]
// Two-entry output buffer: result register plus skid register, so the
// input side can take one more transaction while a result waits. Uses i420ta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i420ta_skid
    import i420ta_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_result i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take, accept;

    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign take    = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            // on a stall, hold the waiting result and park the new transaction in skid
            if (r_out_valid && !take) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[rtl/core/i420ta_checker.sv]
// Port-level checks for i420_frame_transpose_addr, bound to the top level.
// Uses assert_macros.svh and i420ta_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module i420ta_checker
    import i420ta_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [ADDR_W-1:0] o_dest_addr,
    input wire logic [PIX_W-1:0]  o_pixel_out,
    input wire logic              o_frame_last
);

    logic [ADDR_W+PIX_W:0] out_word;

    assign out_word = {o_dest_addr, o_pixel_out, o_frame_last};

    // stalled result stays
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(out_word))
    // input is blocked only behind a stalled result
    `ASSERT_SAME(a_ready_low, i_clk, i_rst_n, !o_in_ready, o_out_valid)
    // a transaction into an empty buffer shows up next cycle
    `ASSERT_NEXT(a_fill, i_clk, i_rst_n, i_in_valid && o_in_ready && !o_out_valid, o_out_valid)

endmodule

bind i420_frame_transpose_addr i420ta_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_dest_addr  (o_dest_addr),
    .o_pixel_out  (o_pixel_out),
    .o_frame_last (o_frame_last)
);

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for i420_frame_transpose_addr: streams I420 frame bytes under many frame
// sizes and checks every destination address, byte and end-of-frame flag against a
// predictor. Depends on i420ta_pkg and the RTL top level only.

module testbench
    import i420ta_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TARGET_ITEMS = 850;
    localparam int LONG_HOLD    = 160;
    localparam int MAX_REPORTS  = 20;

    // Tracks the transposed address of every byte and holds the results still owed.
    class transpose_addr_predictor;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic [1:0]        plane;
        logic [11:0]       row_cnt;
        logic [11:0]       col_cnt;
        logic [ADDR_W-1:0] row_base;
        logic [ADDR_W-1:0] cur_addr;
        t_result           awaited_results[$];
        int                errors;
        int                bytes_taken;
        int                frames_seen;
        logic [ADDR_W-1:0] top_addr;

        function new();
            width_reg   = DIM_W'(RST_W);
            height_reg  = DIM_W'(RST_H);
            plane       = PLANE_Y;
            row_cnt     = '0;
            col_cnt     = '0;
            row_base    = '0;
            cur_addr    = '0;
            errors      = 0;
            bytes_taken = 0;
            frames_seen = 0;
            top_addr    = '0;
        endfunction

        // Drop bit 0, then clamp to 2 .. MAX_DIM.
        static function int clamp_dim(logic [DIM_W-1:0] raw);
            int v;
            v = int'(raw) & ~1;
            if (v < 2) begin
                v = 2;
            end
            if (v > (MAX_DIM & ~1)) begin
                v = MAX_DIM & ~1;
            end
            return v;
        endfunction

        function void set_dim(logic idx, logic [DIM_W-1:0] value);
            if (idx == REG_SRC_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Record an accepted byte; returns the predicted end-of-frame flag.
        function bit note_pixel(logic [PIX_W-1:0] px);
            int                w;
            int                h;
            int                pw;
            int                ph;
            logic [ADDR_W-1:0] luma;
            bit                last_col;
            bit                last_row;
            t_result           r;
            w    = clamp_dim(width_reg);
            h    = clamp_dim(height_reg);
            luma = ADDR_W'(w) * ADDR_W'(h);
            pw   = (plane == PLANE_Y) ? w : (w >> 1);
            ph   = (plane == PLANE_Y) ? h : (h >> 1);
            // a counter at or past the plane limit counts as the last column/row
            last_col = (int'(col_cnt) + 1) >= pw;
            last_row = (int'(row_cnt) + 1) >= ph;

            r.dest_addr  = cur_addr;
            r.pixel      = px;
            r.frame_last = (plane == PLANE_V) && last_col && last_row;
            awaited_results.push_back(r);
            bytes_taken++;

            if (!last_col) begin
                col_cnt++;
                cur_addr = cur_addr + ADDR_W'(ph);
            end else if (!last_row) begin
                col_cnt  = '0;
                row_cnt++;
                row_base = row_base + 1'b1;
                cur_addr = row_base;
            end else begin
                col_cnt = '0;
                row_cnt = '0;
                case (plane)
                    PLANE_Y: begin
                        plane    = PLANE_U;
                        row_base = luma;
                    end
                    PLANE_U: begin
                        plane    = PLANE_V;
                        row_base = luma + (luma >> 2);
                    end
                    default: begin
                        plane    = PLANE_Y;
                        row_base = '0;
                    end
                endcase
                cur_addr = row_base;
            end
            return r.frame_last;
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] px,
                                   logic last);
            t_result want;
            if (awaited_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: result with no transaction waiting, addr 0x%0h byte 0x%0h",
                             $time, addr, px);
                end
                return;
            end
            want = awaited_results.pop_front();
            if (addr !== want.dest_addr) begin
                flag("dest_addr", 32'(want.dest_addr), 32'(addr));
            end
            if (px !== want.pixel) begin
                flag("pixel_out", 32'(want.pixel), 32'(px));
            end
            if (last !== want.frame_last) begin
                flag("frame_last", 32'(want.frame_last), 32'(last));
            end
            if (want.frame_last) begin
                frames_seen++;
            end
            if (want.dest_addr > top_addr) begin
                top_addr = want.dest_addr;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [PIX_W-1:0]   i_pixel;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [ADDR_W-1:0]  o_dest_addr;
    logic [PIX_W-1:0]   o_pixel_out;
    logic               o_frame_last;

    transpose_addr_predictor dest_pred;
    bit hold_request;
    int long_holds;
    int burst_left;
    int cycle_count;
    int settings_used;

    i420_frame_transpose_addr dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_dest_addr  (o_dest_addr),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL i420_frame_transpose_addr");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            dest_pred.check_result(o_dest_addr, o_pixel_out, o_frame_last);
        end
    end

    // Output side: a random stall pattern, redrawn when its run ends; a requested long hold
    // wins over the pattern.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
                long_holds++;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= 1'($urandom_range(0, 1));
                    2:       i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic logic [PIX_W-1:0] corner_byte(int n);
        case (n % 4)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h55;
            default: return 8'hAA;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 5))
                0:       return DIM_W'(1);
                1:       return DIM_W'(4094);
                2:       return DIM_W'(4096);
                3:       return DIM_W'(4097);
                4:       return DIM_W'(8190);
                default: return DIM_W'(8191);
            endcase
        end
        return DIM_W'($urandom_range(0, 9));
    endfunction

    task automatic write_dim(input logic idx, input logic [DIM_W-1:0] value);
        logic [DATA_W-1:0] word;
        word = $urandom();
        word[DIM_W-1:0] = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dest_pred.set_dim(idx, value);
    endtask

    // Between transactions: end the current burst with a gap now and then.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer bytes until max_items are taken or, when frames_wanted is set, that many
    // frames have ended.
    task automatic run_items(input int max_items, input int frames_wanted,
                             input bit corners);
        int               sent;
        int               ends;
        logic [PIX_W-1:0] px;
        sent = 0;
        ends = 0;
        while (sent < max_items && (frames_wanted == 0 || ends < frames_wanted)) begin
            if (sent > 0) begin
                sender_pause();
            end
            px = corners ? corner_byte(sent) : PIX_W'($urandom_range(0, 255));
            i_in_valid <= 1'b1;
            i_pixel    <= px;
            @(posedge i_clk);
            while (!o_in_ready) begin
                @(posedge i_clk);
            end
            ends += dest_pred.note_pixel(px);
            sent++;
        end
        i_in_valid <= 1'b0;
    endtask

    // Hold the input until every result is out.
    task automatic settle();
        while (dest_pred.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        write_dim(REG_SRC_WIDTH, w);
        write_dim(REG_SRC_HEIGHT, h);
        settings_used++;
    endtask

    initial begin
        int phase_no;
        int frame_items;
        int pick;
        dest_pred     = new();
        hold_request  = 1'b0;
        long_holds    = 0;
        burst_left    = 0;
        cycle_count   = 0;
        settings_used = 1;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_pixel    <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size 640 x 480
        run_items(4, 0, 1'b1);
        settle();
        // zero and one act as 2; counters already past the new limits
        set_size(DIM_W'(0), DIM_W'(1));
        run_items(8, 0, 1'b1);
        settle();
        // top of the register range saturates to the largest frame
        set_size(DIM_W'(8191), DIM_W'(8190));
        run_items(4, 0, 1'b1);
        settle();
        // odd sizes lose bit 0
        set_size(DIM_W'(3), DIM_W'(5));
        run_items(8, 0, 1'b1);
        settle();

        phase_no = 0;
        while (dest_pred.bytes_taken < TARGET_ITEMS) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                write_dim(REG_SRC_WIDTH, pick_dim());
                settings_used++;
            end else if (pick == 1) begin
                write_dim(REG_SRC_HEIGHT, pick_dim());
                settings_used++;
            end else begin
                set_size(pick_dim(), pick_dim());
            end
            frame_items = transpose_addr_predictor::clamp_dim(dest_pred.width_reg)
                        * transpose_addr_predictor::clamp_dim(dest_pred.height_reg) * 3 / 2;
            if (phase_no == 2 || phase_no == 9) begin
                // output held off while bytes keep coming
                hold_request = 1'b1;
                run_items(40, 0, 1'b0);
            end else if (frame_items <= 300 && $urandom_range(0, 3) != 0) begin
                run_items(2000, $urandom_range(1, 2), 1'b0);
            end else begin
                run_items($urandom_range(1, 30), 0, 1'b0);
            end
            settle();
            phase_no++;
        end

        $display("Covered %0d transactions under %0d register settings, %0d whole frames.",
                 dest_pred.bytes_taken, settings_used, dest_pred.frames_seen);
        $display("Highest destination address 0x%0h; %0d long output holds; %0d errors.",
                 dest_pred.top_addr, long_holds, dest_pred.errors);
        if (dest_pred.errors == 0) begin
            $display("PASS i420_frame_transpose_addr");
        end else begin
            $display("FAIL i420_frame_transpose_addr");
        end
        $finish;
    end

endmodule

[i420_frame_transpose_addr.f]
+incdir+rtl/core
rtl/core/i420ta_pkg.sv
rtl/core/i420ta_cfg.sv
rtl/core/i420ta_addr_gen.sv
rtl/core/i420ta_skid.sv
rtl/core/i420_frame_transpose_addr.sv
rtl/core/i420ta_checker.sv
test/testbench.sv
